>>> hw/rtl/hsl_pkg.sv
// Shared constants, types and a helper function for the HSL to RGB converter.
package hsl_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned HUE_W     = FRAC_BITS;
  localparam int unsigned SL_W      = FRAC_BITS + 1;
  localparam int unsigned RGB_W     = 8;
  localparam int unsigned NUM_CH    = 3;

  // fixed-point constants, rounded to nearest
  localparam int unsigned ONE_I        = 1 << FRAC_BITS;
  localparam int unsigned HALF_I       = ONE_I / 2;
  localparam int unsigned THIRD_I      = (2 * ONE_I + 3) / 6;
  localparam int unsigned SIXTH_I      = (2 * ONE_I + 6) / 12;
  localparam int unsigned TWO_THIRDS_I = (4 * ONE_I + 3) / 6;

  localparam logic [SL_W-1:0]  FX_ONE        = SL_W'(ONE_I);
  localparam logic [SL_W-1:0]  FX_HALF       = SL_W'(HALF_I);
  localparam logic [HUE_W-1:0] FX_THIRD      = HUE_W'(THIRD_I);
  localparam logic [HUE_W-1:0] FX_SIXTH      = HUE_W'(SIXTH_I);
  localparam logic [HUE_W-1:0] FX_HALF_T     = HUE_W'(HALF_I);
  localparam logic [HUE_W-1:0] FX_TWO_THIRDS = HUE_W'(TWO_THIRDS_I);

  // channel value after the ramp; may overshoot one slightly
  localparam int unsigned CH_W = FRAC_BITS + 2;

  typedef enum logic [1:0] {
    RGN_RISE,
    RGN_HIGH,
    RGN_FALL,
    RGN_LOW
  } region_e;

  typedef struct packed {
    region_e             rgn;
    logic [HUE_W-1:0]    u;    // ramp factor, t or two_thirds - t
  } chan_t;

  typedef struct packed {
    logic [SL_W-1:0]        p;
    logic [SL_W-1:0]        q;
    logic [SL_W-1:0]        d;
    chan_t [NUM_CH-1:0]     ch;
  } qp_t;

  typedef logic [CH_W-1:0] chan_val_t;

  typedef struct packed {
    chan_val_t [NUM_CH-1:0] c;
  } lvl_t;

  // classify a hue position on the piecewise-linear ramp
  function automatic chan_t hue_chan(logic [HUE_W-1:0] t);
    chan_t r;
    if (t < FX_SIXTH) begin
      r.rgn = RGN_RISE;
      r.u   = t;
    end else if (t < FX_HALF_T) begin
      r.rgn = RGN_HIGH;
      r.u   = '0;
    end else if (t < FX_TWO_THIRDS) begin
      r.rgn = RGN_FALL;
      r.u   = FX_TWO_THIRDS - t;
    end else begin
      r.rgn = RGN_LOW;
      r.u   = '0;
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/hsl_if.sv
// Valid/ready channel interfaces for HSL input words and RGB output words.
interface hsl_in_if;
  logic                          valid;
  logic                          ready;
  logic [hsl_pkg::HUE_W-1:0]     hue;
  logic [hsl_pkg::SL_W-1:0]      saturation;
  logic [hsl_pkg::SL_W-1:0]      lightness;

  modport source (output valid, hue, saturation, lightness, input ready);
  modport sink   (input valid, hue, saturation, lightness, output ready);
endinterface

interface hsl_rgb_if;
  logic                          valid;
  logic                          ready;
  logic [hsl_pkg::RGB_W-1:0]     red;
  logic [hsl_pkg::RGB_W-1:0]     green;
  logic [hsl_pkg::RGB_W-1:0]     blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

>>> hw/rtl/hsl_qp_calc.sv
// Stages 1-2: clamp inputs, form l*s and hue positions, then q, p and q-p.
module hsl_qp_calc (
  input  logic          clk_i,
  input  logic          rst_ni,
  hsl_in_if.sink        in_i,
  output logic          valid_o,
  input  logic          ready_i,
  output hsl_pkg::qp_t  qp_o
);

  localparam int unsigned F  = hsl_pkg::FRAC_BITS;
  localparam int unsigned SW = hsl_pkg::SL_W;
  localparam int unsigned PW = 2 * F + 2;

  logic en1, en2;
  logic v1_q, v2_q;

  logic [SW-1:0]  s_c, l_c;
  logic [SW-1:0]  s1_q, l1_q;
  logic [PW-1:0]  ls1_q;
  hsl_pkg::chan_t [hsl_pkg::NUM_CH-1:0] ch_d, ch1_q;

  logic [PW-1:0]  ls_up;
  logic [F+1:0]   q_w;
  logic [SW-1:0]  q_c, p_c;
  logic [F+2:0]   two_l, p_w;
  hsl_pkg::qp_t   qp_d, qp_q;

  // a stage advances when empty or when the next one advances
  assign en2        = !v2_q || ready_i;
  assign en1        = !v1_q || en2;
  assign in_i.ready = en1;

  always_comb begin
    s_c = (in_i.saturation > hsl_pkg::FX_ONE) ? hsl_pkg::FX_ONE : in_i.saturation;
    l_c = (in_i.lightness  > hsl_pkg::FX_ONE) ? hsl_pkg::FX_ONE : in_i.lightness;
    ch_d[0] = hsl_pkg::hue_chan(in_i.hue + hsl_pkg::FX_THIRD);
    ch_d[1] = hsl_pkg::hue_chan(in_i.hue);
    ch_d[2] = hsl_pkg::hue_chan(in_i.hue - hsl_pkg::FX_THIRD);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_i.valid;
      if (en2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_q  <= s_c;
      l1_q  <= l_c;
      ls1_q <= PW'(s_c * l_c);
      ch1_q <= ch_d;
    end
  end

  always_comb begin
    // ceil(l*s / one) for the upper half of lightness
    ls_up = ls1_q + PW'(hsl_pkg::ONE_I - 1);
    if (l1_q < hsl_pkg::FX_HALF) begin
      q_w = (F+2)'(l1_q) + ls1_q[PW-1:F];
    end else begin
      q_w = (F+2)'(l1_q) + (F+2)'(s1_q) - ls_up[PW-1:F];
    end
    q_c   = q_w[SW-1:0];
    two_l = {1'b0, l1_q, 1'b0};
    p_w   = two_l - {2'b00, q_c};
    // clamp p to q on any underflow or overshoot
    if (p_w[F+2] || (p_w[F+1:0] > {1'b0, q_c})) begin
      p_c = q_c;
    end else begin
      p_c = p_w[SW-1:0];
    end
    qp_d.p  = p_c;
    qp_d.q  = q_c;
    qp_d.d  = q_c - p_c;
    qp_d.ch = ch1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en2) qp_q <= qp_d;
  end

  assign valid_o = v2_q;
  assign qp_o    = qp_q;

  a_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> (s1_q <= hsl_pkg::FX_ONE) && (l1_q <= hsl_pkg::FX_ONE))
    else $error("clamped saturation or lightness above one");

  a_p_le_q: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> (qp_q.p <= qp_q.q) && (qp_q.d == qp_q.q - qp_q.p))
    else $error("p above q or bad difference");

  a_q_le_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> qp_q.q <= hsl_pkg::FX_ONE)
    else $error("q above one");

endmodule

>>> hw/rtl/hsl_ramp.sv
// Stages 3-4: ramp products per channel, then the channel level in fixed point.
module hsl_ramp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  hsl_pkg::qp_t  qp_i,
  output logic          valid_o,
  input  logic          ready_i,
  output hsl_pkg::lvl_t lvl_o
);

  localparam int unsigned F  = hsl_pkg::FRAC_BITS;
  localparam int unsigned SW = hsl_pkg::SL_W;
  localparam int unsigned NC = hsl_pkg::NUM_CH;
  localparam int unsigned MW = 2 * F + 1;
  localparam int unsigned XW = MW + 3;

  logic en3, en4;
  logic v3_q, v4_q;

  logic [MW-1:0]     m3_q [NC];
  logic [SW-1:0]     p3_q, q3_q;
  hsl_pkg::region_e  rgn3_q [NC];

  logic [XW-1:0]     prod6 [NC];
  logic [F+3:0]      sum   [NC];
  hsl_pkg::lvl_t     lvl_d, lvl_q;

  assign en4     = !v4_q || ready_i;
  assign en3     = !v3_q || en4;
  assign ready_o = en3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en3) v3_q <= valid_i;
      if (en4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      p3_q <= qp_i.p;
      q3_q <= qp_i.q;
      for (int i = 0; i < NC; i++) begin
        m3_q[i]   <= MW'(qp_i.d * qp_i.ch[i].u);
        rgn3_q[i] <= qp_i.ch[i].rgn;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NC; i++) begin
      // times six as two shifted adds, then drop the fraction
      prod6[i] = ({3'b000, m3_q[i]} << 2) + ({3'b000, m3_q[i]} << 1);
      sum[i]   = (F+4)'(p3_q) + prod6[i][XW-1:F];
      unique case (rgn3_q[i])
        hsl_pkg::RGN_RISE,
        hsl_pkg::RGN_FALL: lvl_d.c[i] = sum[i][hsl_pkg::CH_W-1:0];
        hsl_pkg::RGN_HIGH: lvl_d.c[i] = hsl_pkg::CH_W'(q3_q);
        hsl_pkg::RGN_LOW:  lvl_d.c[i] = hsl_pkg::CH_W'(p3_q);
        default:           lvl_d.c[i] = hsl_pkg::CH_W'(p3_q);
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) lvl_q <= lvl_d;
  end

  assign valid_o = v4_q;
  assign lvl_o   = lvl_q;

endmodule

>>> hw/rtl/hsl_byte.sv
// Stage 5: scale each channel level by 255, truncate and saturate to 8 bits.
module hsl_byte (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  hsl_pkg::lvl_t lvl_i,
  hsl_rgb_if.source     out_o
);

  localparam int unsigned F  = hsl_pkg::FRAC_BITS;
  localparam int unsigned CW = hsl_pkg::CH_W;
  localparam int unsigned NC = hsl_pkg::NUM_CH;
  localparam int unsigned XW = CW + 8;

  logic                       v5_q;
  logic                       en5;
  logic [XW-1:0]              x   [NC];
  logic [XW-F-1:0]            v   [NC];
  logic [hsl_pkg::RGB_W-1:0]  b_d [NC];
  logic [hsl_pkg::RGB_W-1:0]  b_q [NC];

  assign en5     = !v5_q || out_o.ready;
  assign ready_o = en5;

  always_comb begin
    for (int i = 0; i < NC; i++) begin
      x[i]   = ({8'h00, lvl_i.c[i]} << 8) - {8'h00, lvl_i.c[i]};
      v[i]   = x[i][XW-1:F];
      b_d[i] = (v[i] > (XW-F)'(255)) ? 8'hFF : v[i][hsl_pkg::RGB_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en5) begin
      v5_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en5) begin
      for (int i = 0; i < NC; i++) b_q[i] <= b_d[i];
    end
  end

  assign out_o.valid = v5_q;
  assign out_o.red   = b_q[0];
  assign out_o.green = b_q[1];
  assign out_o.blue  = b_q[2];

endmodule

>>> hw/rtl/hsl_to_rgb_convert.sv
// HSL to RGB converter top level: five-stage valid/ready pipeline.
// Takes one hue/saturation/lightness word per clock and returns one 8-bit
// red/green/blue word per clock unless the output stalls. Each of the
// five register stages holds its own valid bit and advances when empty
// or when the stage after it advances, so a stall on the output backs up
// stage by stage and empty slots close up. The stage depth is set by the
// multipliers: one 17x17 product for l*s in stage 1 and three 17x16 ramp
// products in stage 3, each followed by a register.
module hsl_to_rgb_convert (
  input  logic       clk_i,
  input  logic       rst_ni,
  hsl_in_if.sink     in_i,
  hsl_rgb_if.source  out_o
);

  logic          qp_valid, qp_ready;
  hsl_pkg::qp_t  qp;
  logic          lvl_valid, lvl_ready;
  hsl_pkg::lvl_t lvl;

  hsl_qp_calc u_qp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .valid_o (qp_valid),
    .ready_i (qp_ready),
    .qp_o    (qp)
  );

  hsl_ramp u_ramp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (qp_valid),
    .ready_o (qp_ready),
    .qp_i    (qp),
    .valid_o (lvl_valid),
    .ready_i (lvl_ready),
    .lvl_o   (lvl)
  );

  hsl_byte u_byte (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (lvl_valid),
    .ready_o (lvl_ready),
    .lvl_i   (lvl),
    .out_o   (out_o)
  );

endmodule

>>> bench/hsl_to_rgb_convert_tb.sv
// Self-checking bench for the HSL to RGB converter: directed, random and backpressure tests.
module hsl_to_rgb_convert_tb;

  localparam int unsigned FB         = hsl_pkg::FRAC_BITS;
  localparam longint unsigned UNIT   = 64'd1 << FB;
  localparam longint unsigned HALF   = UNIT >> 1;
  localparam longint unsigned THIRD  = (2 * UNIT + 3) / 6;
  localparam longint unsigned SIXTH  = (2 * UNIT + 6) / 12;
  localparam longint unsigned TWO_3  = (4 * UNIT + 3) / 6;
  localparam int unsigned SHOWN_MAX  = 10;
  localparam int unsigned TAIL_CYC   = 10;

  typedef logic [hsl_pkg::HUE_W-1:0] hue_t;
  typedef logic [hsl_pkg::SL_W-1:0]  unit_t;

  typedef struct packed {
    logic [hsl_pkg::RGB_W-1:0] red;
    logic [hsl_pkg::RGB_W-1:0] green;
    logic [hsl_pkg::RGB_W-1:0] blue;
  } rgb_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  hsl_in_if  in_bus ();
  hsl_rgb_if out_bus ();

  hsl_to_rgb_convert dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always #1 clk_i = ~clk_i;

  rgb_word_t   expected_rgb[$];
  int unsigned errors = 0;
  bit          source_idle_on = 1'b0;
  bit          sink_idle_on = 1'b0;
  int unsigned sink_hold_req = 0;

  // ramp position t to channel level
  function automatic longint unsigned ramp_level(longint unsigned p, longint unsigned q,
                                                 longint unsigned t);
    longint unsigned d;
    d = q - p;
    if (t < SIXTH) return p + ((d * 6 * t) >> FB);
    if (t < HALF) return q;
    if (t < TWO_3) return p + ((d * (TWO_3 - t) * 6) >> FB);
    return p;
  endfunction

  function automatic logic [7:0] scale_byte(longint unsigned c);
    longint unsigned v;
    v = (c * 255) >> FB;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic rgb_word_t predict_rgb(hue_t h, unit_t s_in, unit_t l_in);
    longint unsigned s, l, q, p, hh;
    rgb_word_t w;
    hh = longint'(h) & (UNIT - 1);
    s = (s_in > UNIT) ? UNIT : longint'(s_in);
    l = (l_in > UNIT) ? UNIT : longint'(l_in);
    if (l < HALF) q = (l * (UNIT + s)) >> FB;
    else q = (l * UNIT + s * UNIT - l * s) >> FB;
    p = 2 * l - q;
    if (p > q) p = q;
    w.red   = scale_byte(ramp_level(p, q, (hh + THIRD) & (UNIT - 1)));
    w.green = scale_byte(ramp_level(p, q, hh));
    w.blue  = scale_byte(ramp_level(p, q, (hh + UNIT - THIRD) & (UNIT - 1)));
    return w;
  endfunction

  // mostly in range, with the end points and the clamped region mixed in
  function automatic unit_t rand_unit();
    case ($urandom_range(0, 9))
      0: return unit_t'(0);
      1: return unit_t'(UNIT);
      2: return unit_t'($urandom_range(32'(UNIT + 1), 32'(2 * UNIT - 1)));
      default: return unit_t'($urandom_range(0, 32'(UNIT)));
    endcase
  endfunction

  task automatic send_hsl(input hue_t h, input unit_t s, input unit_t l);
    int unsigned gap;
    gap = 0;
    if (source_idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 11);
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid      <= 1'b1;
    in_bus.hue        <= h;
    in_bus.saturation <= s;
    in_bus.lightness  <= l;
    do @(posedge clk_i); while (!in_bus.ready);
    expected_rgb = {expected_rgb, predict_rgb(h, s, l)};
  endtask

  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    while (expected_rgb.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    source_idle_on = 1'b0;
    sink_idle_on   = 1'b0;
    send_hsl(hue_t'(0), unit_t'(0), unit_t'(0));
    send_hsl(hue_t'(0), unit_t'(0), unit_t'(UNIT));
    send_hsl(hue_t'(0), unit_t'(UNIT), unit_t'(HALF));
    send_hsl(hue_t'(THIRD), unit_t'(UNIT), unit_t'(HALF));
    send_hsl(hue_t'(TWO_3), unit_t'(UNIT), unit_t'(HALF));
    send_hsl(hue_t'(UNIT - 1), unit_t'(UNIT), unit_t'(HALF));
    // region boundaries of the green ramp
    send_hsl(hue_t'(SIXTH - 1), unit_t'(UNIT), unit_t'(HALF));
    send_hsl(hue_t'(SIXTH), unit_t'(UNIT), unit_t'(HALF));
    send_hsl(hue_t'(HALF - 1), unit_t'(UNIT), unit_t'(HALF));
    // falling ramp overshoots one here and must still scale to 255
    send_hsl(hue_t'(HALF), unit_t'(UNIT), unit_t'(HALF));
    send_hsl(hue_t'(HALF + 1), unit_t'(UNIT), unit_t'(HALF));
    send_hsl(hue_t'(TWO_3 - 1), unit_t'(UNIT), unit_t'(HALF));
    send_hsl(hue_t'(TWO_3), unit_t'(UNIT), unit_t'(HALF));
    // saturation and lightness above one clamp
    send_hsl(hue_t'(1000), unit_t'(2 * UNIT - 1), unit_t'(20000));
    send_hsl(hue_t'(1000), unit_t'(30000), unit_t'(2 * UNIT - 1));
    send_hsl(hue_t'(UNIT - 1), unit_t'(2 * UNIT - 1), unit_t'(2 * UNIT - 1));
    // either side of the lightness split
    send_hsl(hue_t'(5000), unit_t'(40000), unit_t'(HALF - 1));
    send_hsl(hue_t'(5000), unit_t'(40000), unit_t'(HALF));
    send_hsl(hue_t'(12345), unit_t'(UNIT), unit_t'(UNIT));
    send_hsl(hue_t'(THIRD), unit_t'(0), unit_t'(HALF));
    send_hsl(hue_t'(43690), unit_t'(UNIT - 1), unit_t'(1));
  endtask

  task automatic test_random_idle(input int unsigned count);
    source_idle_on = 1'b1;
    sink_idle_on   = 1'b1;
    repeat (count) send_hsl(hue_t'($urandom), rand_unit(), rand_unit());
  endtask

  task automatic test_sink_hold();
    source_idle_on = 1'b0;
    sink_idle_on   = 1'b0;
    sink_hold_req  = 80;
    // keep offering so the pipeline fills and stalls the input
    repeat (40) send_hsl(hue_t'($urandom), rand_unit(), rand_unit());
  endtask

  task automatic test_source_pause();
    source_idle_on = 1'b1;
    sink_idle_on   = 1'b1;
    repeat (20) send_hsl(hue_t'($urandom), rand_unit(), rand_unit());
    wait_drained();
    repeat (20) send_hsl(hue_t'($urandom), rand_unit(), rand_unit());
  endtask

  task automatic test_full_rate(input int unsigned count);
    source_idle_on = 1'b0;
    sink_idle_on   = 1'b0;
    repeat (count) send_hsl(hue_t'($urandom), rand_unit(), rand_unit());
  endtask

  // receiver: random stall bursts and long hold-offs on request
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (sink_hold_req != 0) begin
        stall_left    = sink_hold_req;
        sink_hold_req = 0;
      end
      if (stall_left != 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        out_bus.ready <= 1'b0;
        stall_left = $urandom_range(1, 11) - 1;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_rgb
    rgb_word_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (expected_rgb.size() == 0) begin
        errors++;
        if (errors <= SHOWN_MAX)
          $display("unexpected rgb word r=%0d g=%0d b=%0d",
                   out_bus.red, out_bus.green, out_bus.blue);
      end else begin
        want = expected_rgb.pop_front();
        if (out_bus.red !== want.red || out_bus.green !== want.green ||
            out_bus.blue !== want.blue) begin
          errors++;
          if (errors <= SHOWN_MAX)
            $display("rgb mismatch: want r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                     want.red, want.green, want.blue,
                     out_bus.red, out_bus.green, out_bus.blue);
        end
      end
    end
  end

  initial begin
    #400000;
    $display("hsl_to_rgb_convert_tb: errors");
    $finish;
  end

  initial begin
    rst_ni            <= 1'b0;
    in_bus.valid      <= 1'b0;
    in_bus.hue        <= '0;
    in_bus.saturation <= '0;
    in_bus.lightness  <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_idle(480);
    test_sink_hold();
    test_source_pause();
    test_full_rate(450);

    wait_drained();
    repeat (TAIL_CYC) @(posedge clk_i);
    if (errors == 0) $display("hsl_to_rgb_convert_tb: clean");
    else $display("hsl_to_rgb_convert_tb: errors");
    $finish;
  end

endmodule
